/* hdl/lgs_pkg.sv */
package lgs_pkg;

  localparam int GRID_SIZE_DEF = 16;
  localparam int COORD_W = 4;
  localparam int GEN_W = 32;
  localparam int COUNT_W = 4;

  localparam logic [COUNT_W-1:0] BORN_COUNT = 4'd3;
  localparam logic [COUNT_W-1:0] KEEP_COUNT = 4'd2;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_PRIME,
    ST_RUN,
    ST_OUT
  } state_t;

endpackage

/* hdl/lgs_ram.sv */
module lgs_ram #(
  parameter int WIDTH = lgs_pkg::GRID_SIZE_DEF,
  parameter int DEPTH = lgs_pkg::GRID_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/lgs_row_unit.sv */
module lgs_row_unit #(
  parameter int GRID_SIZE = lgs_pkg::GRID_SIZE_DEF
) (
  input  logic [GRID_SIZE-1:0] above,
  input  logic [GRID_SIZE-1:0] middle,
  input  logic [GRID_SIZE-1:0] below,
  output logic [GRID_SIZE-1:0] next_row
);

  // Each row is padded with a dead cell on both sides, so the edges do not wrap.
  logic [GRID_SIZE+1:0] above_ext;
  logic [GRID_SIZE+1:0] middle_ext;
  logic [GRID_SIZE+1:0] below_ext;

  assign above_ext  = {1'b0, above, 1'b0};
  assign middle_ext = {1'b0, middle, 1'b0};
  assign below_ext  = {1'b0, below, 1'b0};

  always_comb begin
    logic [lgs_pkg::COUNT_W-1:0] n;
    next_row = '0;
    for (int c = 0; c < GRID_SIZE; c++) begin
      n = lgs_pkg::COUNT_W'(above_ext[c]) + lgs_pkg::COUNT_W'(above_ext[c+1])
        + lgs_pkg::COUNT_W'(above_ext[c+2]) + lgs_pkg::COUNT_W'(middle_ext[c])
        + lgs_pkg::COUNT_W'(middle_ext[c+2]) + lgs_pkg::COUNT_W'(below_ext[c])
        + lgs_pkg::COUNT_W'(below_ext[c+1]) + lgs_pkg::COUNT_W'(below_ext[c+2]);
      next_row[c] = (n == lgs_pkg::BORN_COUNT) || (middle[c] && (n == lgs_pkg::KEEP_COUNT));
    end
  end

endmodule

/* hdl/life_grid_generation_step_unit.sv */
// Channel  Direction  Handshake           Word
// in       input      in_valid/in_stall   command, row, column, value
// out      output     out_valid/out_stall cell_alive, generation
//
// A write or read goes through ST_ACCESS to ST_OUT, an unused command straight to ST_OUT.
// A step goes through ST_PRIME and ST_RUN to ST_OUT: in ST_RUN one grid row per cycle
// goes through the shared row unit, paced by the single read port of the row memory.
// From ST_OUT the unit returns to ST_IDLE before the next word can be taken.
// Reset clears the generation counter and one valid bit per row.
// in_stall is high while a word is being worked on; a finished result waits for the
// output register to free up, while a word already in that register waits for out_stall.
module life_grid_generation_step_unit #(
  parameter int GRID_SIZE = lgs_pkg::GRID_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic [lgs_pkg::COORD_W-1:0] row,
  input  logic [lgs_pkg::COORD_W-1:0] column,
  input  logic                        value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        cell_alive,
  output logic [lgs_pkg::GEN_W-1:0]   generation
);

  localparam int AW = $clog2(GRID_SIZE);
  localparam logic [AW-1:0] LAST_ROW = AW'(GRID_SIZE - 1);

  lgs_pkg::state_t state;
  lgs_pkg::state_t state_next;

  logic                      in_accept;
  logic                      in_grid;
  logic [AW-1:0]             in_row_idx;
  logic [1:0]                cmd_q;
  logic [AW-1:0]             row_q;
  logic [AW-1:0]             col_q;
  logic                      value_q;
  logic                      in_grid_q;
  logic [AW-1:0]             cnt;
  logic                      last;
  logic [GRID_SIZE-1:0]      up;
  logic [GRID_SIZE-1:0]      mid;
  logic [GRID_SIZE-1:0]      down;
  logic [GRID_SIZE-1:0]      next_row;
  logic [GRID_SIZE-1:0]      written_row;
  logic [GRID_SIZE-1:0]      row_valid;
  logic                      rd_ok;
  logic [GRID_SIZE-1:0]      rd_data;
  logic [GRID_SIZE-1:0]      rd_row;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [GRID_SIZE-1:0]      wr_data;
  logic [lgs_pkg::GEN_W-1:0] gen;
  logic                      res_alive;
  logic                      access_alive;
  logic                      out_free;
  logic                      out_load;

  assign in_stall   = (state != lgs_pkg::ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign in_grid    = (int'(row) < GRID_SIZE) && (int'(column) < GRID_SIZE);
  assign in_row_idx = AW'(row);
  assign last       = (cnt == LAST_ROW);
  assign rd_row     = rd_ok ? rd_data : '0;
  assign down       = last ? '0 : rd_row;
  assign out_free   = !out_valid || !out_stall;
  assign out_load   = (state == lgs_pkg::ST_OUT) && out_free;

  always_comb begin
    written_row = rd_row;
    written_row[col_q] = value_q;
  end

  assign access_alive = in_grid_q &&
                        ((cmd_q == lgs_pkg::CMD_WRITE) ? value_q : rd_row[col_q]);

  lgs_ram #(
    .WIDTH(GRID_SIZE),
    .DEPTH(GRID_SIZE)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lgs_row_unit #(
    .GRID_SIZE(GRID_SIZE)
  ) u_row_unit (
    .above    (up),
    .middle   (mid),
    .below    (down),
    .next_row (next_row)
  );

  always_comb begin
    state_next = state;
    case (state)
      lgs_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (command inside {lgs_pkg::CMD_WRITE, lgs_pkg::CMD_READ}) begin
            state_next = lgs_pkg::ST_ACCESS;
          end else if (command == lgs_pkg::CMD_STEP) begin
            state_next = lgs_pkg::ST_PRIME;
          end else begin
            state_next = lgs_pkg::ST_OUT;
          end
        end
      end
      lgs_pkg::ST_ACCESS: state_next = lgs_pkg::ST_OUT;
      lgs_pkg::ST_PRIME:  state_next = lgs_pkg::ST_RUN;
      lgs_pkg::ST_RUN: begin
        if (last) begin
          state_next = lgs_pkg::ST_OUT;
        end
      end
      lgs_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = lgs_pkg::ST_IDLE;
        end
      end
      default: state_next = lgs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state)
      lgs_pkg::ST_IDLE: begin
        if (in_accept) begin
          if ((command inside {lgs_pkg::CMD_WRITE, lgs_pkg::CMD_READ}) && in_grid) begin
            rd_en   = 1'b1;
            rd_addr = in_row_idx;
          end else if (command == lgs_pkg::CMD_STEP) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
        end
      end
      lgs_pkg::ST_ACCESS: begin
        if ((cmd_q == lgs_pkg::CMD_WRITE) && in_grid_q) begin
          wr_en   = 1'b1;
          wr_addr = row_q;
          wr_data = written_row;
        end
      end
      lgs_pkg::ST_PRIME: begin
        rd_en   = 1'b1;
        rd_addr = AW'(1);
      end
      lgs_pkg::ST_RUN: begin
        wr_en   = 1'b1;
        wr_addr = cnt;
        wr_data = next_row;
        if (int'(cnt) < GRID_SIZE - 2) begin
          rd_en   = 1'b1;
          rd_addr = cnt + AW'(2);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lgs_pkg::ST_IDLE;
      gen       <= '0;
      row_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if ((state == lgs_pkg::ST_RUN) && last) begin
        gen <= gen + lgs_pkg::GEN_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_q     <= command;
      row_q     <= in_row_idx;
      col_q     <= AW'(column);
      value_q   <= value;
      in_grid_q <= in_grid;
      res_alive <= 1'b0;
    end
    if (rd_en) begin
      rd_ok <= row_valid[rd_addr];
    end
    if (state == lgs_pkg::ST_ACCESS) begin
      res_alive <= access_alive;
    end
    if (state == lgs_pkg::ST_PRIME) begin
      up  <= '0;
      mid <= rd_row;
      cnt <= '0;
    end
    if (state == lgs_pkg::ST_RUN) begin
      up  <= mid;
      mid <= down;
      if (!last) begin
        cnt <= cnt + AW'(1);
      end
    end
    if (out_load) begin
      cell_alive <= res_alive;
      generation <= gen;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("Row memory read and written at the same address in one cycle.");

  assert property (@(posedge clk) disable iff (rst)
    (state == lgs_pkg::ST_RUN && last) |=> (gen == $past(gen) + lgs_pkg::GEN_W'(1)))
    else $error("Generation counter did not advance at the end of a step.");

  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (gen != $past(gen))) |-> (gen == $past(gen) + lgs_pkg::GEN_W'(1)))
    else $error("Generation counter changed by other than one.");

endmodule

/* verif/life_grid_generation_step_unit_test.sv */
module life_grid_generation_step_unit_test;

  localparam int GRID = lgs_pkg::GRID_SIZE_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_WORDS = 400;

  typedef struct packed {
    logic [1:0]                  cmd;
    logic [lgs_pkg::COORD_W-1:0] row;
    logic [lgs_pkg::COORD_W-1:0] col;
    logic                        value;
    logic                        drain;
  } grid_word_t;

  typedef struct packed {
    logic                      cell_alive;
    logic [lgs_pkg::GEN_W-1:0] generation;
  } life_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = lgs_pkg::CMD_WRITE;
  logic [lgs_pkg::COORD_W-1:0] row = '0;
  logic [lgs_pkg::COORD_W-1:0] column = '0;
  logic value = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic cell_alive;
  logic [lgs_pkg::GEN_W-1:0] generation;

  life_grid_generation_step_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .row(row),
    .column(column),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cell_alive(cell_alive),
    .generation(generation)
  );

  logic [GRID-1:0][GRID-1:0] cells = '0;
  logic [lgs_pkg::GEN_W-1:0] gen_count = '0;

  grid_word_t pending_words[$];
  life_result_t expected_results[$];

  int words_offered = 0;
  int in_accepts = 0;
  int results_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int hold_left = 0;
  int drains_done = 0;
  int n_writes = 0;
  int n_reads = 0;
  int n_steps = 0;
  int n_unused = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  function automatic life_result_t apply_life_command(logic [1:0] cmd,
                                                      logic [lgs_pkg::COORD_W-1:0] r,
                                                      logic [lgs_pkg::COORD_W-1:0] c,
                                                      logic v);
    life_result_t res;
    logic [GRID-1:0][GRID-1:0] old_rows;
    int nbrs;
    int rr;
    int cc;
    bit on_grid;
    res.cell_alive = 1'b0;
    on_grid = (r < GRID) && (c < GRID);
    case (cmd)
      lgs_pkg::CMD_WRITE: begin
        if (on_grid) begin
          cells[r][c] = v;
          res.cell_alive = v;
        end
      end
      lgs_pkg::CMD_STEP: begin
        old_rows = cells;
        for (int y = 0; y < GRID; y++) begin
          for (int x = 0; x < GRID; x++) begin
            nbrs = 0;
            for (int dy = -1; dy <= 1; dy++) begin
              for (int dx = -1; dx <= 1; dx++) begin
                rr = y + dy;
                cc = x + dx;
                if ((dy != 0 || dx != 0) && rr >= 0 && rr < GRID && cc >= 0 && cc < GRID)
                  nbrs += old_rows[rr][cc];
              end
            end
            cells[y][x] = (nbrs == lgs_pkg::BORN_COUNT) ||
                          (old_rows[y][x] && nbrs == lgs_pkg::KEEP_COUNT);
          end
        end
        gen_count = gen_count + 1'b1;
      end
      lgs_pkg::CMD_READ: begin
        if (on_grid)
          res.cell_alive = cells[r][c];
      end
      default: ;
    endcase
    res.generation = gen_count;
    return res;
  endfunction

  function automatic void add_word(logic [1:0] cmd, int r, int c, logic v);
    grid_word_t w;
    w.cmd = cmd;
    w.row = r[lgs_pkg::COORD_W-1:0];
    w.col = c[lgs_pkg::COORD_W-1:0];
    w.value = v;
    w.drain = 1'b0;
    pending_words.push_back(w);
  endfunction

  function automatic void add_drain();
    grid_word_t w;
    w = '0;
    w.drain = 1'b1;
    pending_words.push_back(w);
  endfunction

  function automatic int draw_wait(bit calm);
    if (calm)
      return 0;
    return $urandom_range(0, 8);
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    grid_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_accepts != words_offered)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (pending_words.size() > 0 && pending_words[0].drain) begin
        in_valid <= 1'b0;
        if (expected_results.size() == 0) begin
          void'(pending_words.pop_front());
          drains_done++;
        end
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        command <= w.cmd;
        row <= w.row;
        column <= w.col;
        value <= w.value;
        in_valid <= 1'b1;
        words_offered++;
        if ($urandom_range(0, 23) == 0)
          send_calm = !send_calm;
        send_gap = draw_wait(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (results_taken != results_seen) begin
        results_seen = results_taken;
        if ($urandom_range(0, 23) == 0)
          recv_calm = !recv_calm;
        hold_left = draw_wait(recv_calm);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        if (out_valid)
          hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    life_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_life_command(command, row, column, value));
        in_accepts <= in_accepts + 1;
        case (command)
          lgs_pkg::CMD_WRITE: n_writes++;
          lgs_pkg::CMD_STEP:  n_steps++;
          lgs_pkg::CMD_READ:  n_reads++;
          default:            n_unused++;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_taken <= results_taken + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("result word arrived with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (cell_alive !== want.cell_alive)
            report_mismatch($sformatf("cell_alive got %b want %b", cell_alive, want.cell_alive));
          if (generation !== want.generation)
            report_mismatch($sformatf("generation got %0d want %0d", generation,
                                      want.generation));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    int added;
    int r0;
    int c0;
    int density;
    int nseed;
    int nrest;
    int pick;
    int rr;
    int cc;

    // Directed: empty grid, unused command, a blinker on the right edge, three cells of a
    // corner block that grow into the block, overwrite with dead, and steps with readback.
    add_drain();
    add_word(lgs_pkg::CMD_READ, 0, 0, 1'b1);
    add_word(CMD_UNUSED, 15, 15, 1'b1);
    add_word(lgs_pkg::CMD_READ, 15, 15, 1'b0);
    add_word(lgs_pkg::CMD_WRITE, 0, 15, 1'b1);
    add_word(lgs_pkg::CMD_WRITE, 1, 15, 1'b1);
    add_word(lgs_pkg::CMD_WRITE, 2, 15, 1'b1);
    add_word(lgs_pkg::CMD_WRITE, 15, 0, 1'b1);
    add_word(lgs_pkg::CMD_WRITE, 15, 1, 1'b1);
    add_word(lgs_pkg::CMD_WRITE, 14, 0, 1'b1);
    add_word(lgs_pkg::CMD_WRITE, 8, 8, 1'b1);
    add_word(lgs_pkg::CMD_READ, 8, 8, 1'b0);
    add_word(lgs_pkg::CMD_WRITE, 8, 8, 1'b0);
    add_word(lgs_pkg::CMD_READ, 8, 8, 1'b1);
    add_word(lgs_pkg::CMD_STEP, 0, 0, 1'b0);
    add_word(lgs_pkg::CMD_READ, 1, 14, 1'b0);
    add_word(lgs_pkg::CMD_READ, 0, 15, 1'b0);
    add_word(lgs_pkg::CMD_READ, 14, 1, 1'b0);
    add_word(lgs_pkg::CMD_STEP, 15, 15, 1'b1);
    add_word(lgs_pkg::CMD_READ, 0, 15, 1'b1);
    add_word(lgs_pkg::CMD_READ, 15, 0, 1'b0);
    add_word(lgs_pkg::CMD_READ, 14, 1, 1'b1);
    add_word(CMD_UNUSED, 0, 0, 1'b0);
    add_drain();

    // Random: each phase seeds a window with a chosen density, then runs steps
    // mixed with reads, stray writes and unused commands.
    added = 0;
    while (added < RANDOM_WORDS) begin
      r0 = $urandom_range(0, GRID - 6);
      c0 = $urandom_range(0, GRID - 6);
      density = $urandom_range(2, 9);
      nseed = $urandom_range(8, 24);
      for (int i = 0; i < nseed; i++)
        add_word(lgs_pkg::CMD_WRITE, r0 + $urandom_range(0, 5), c0 + $urandom_range(0, 5),
                 $urandom_range(0, 9) < density);
      nrest = $urandom_range(6, 16);
      for (int i = 0; i < nrest; i++) begin
        pick = $urandom_range(0, 19);
        if ($urandom_range(0, 1) == 0) begin
          rr = r0 + $urandom_range(0, 5);
          cc = c0 + $urandom_range(0, 5);
        end else begin
          rr = $urandom_range(0, GRID - 1);
          cc = $urandom_range(0, GRID - 1);
        end
        if (pick < 11)
          add_word(lgs_pkg::CMD_STEP, $urandom_range(0, 15), $urandom_range(0, 15),
                   1'($urandom_range(0, 1)));
        else if (pick < 18)
          add_word(lgs_pkg::CMD_READ, rr, cc, 1'($urandom_range(0, 1)));
        else if (pick == 18)
          add_word(CMD_UNUSED, rr, cc, 1'($urandom_range(0, 1)));
        else
          add_word(lgs_pkg::CMD_WRITE, rr, cc, 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 3) == 0)
        add_drain();
      added += nseed + nrest;
    end

    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d writes, %0d reads, %0d steps and %0d unused commands.",
             n_writes, n_reads, n_steps, n_unused);
    $display("Checked %0d result words across %0d full drains; %0d mismatches.",
             results_taken, drains_done, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/lgs_pkg.sv
hdl/lgs_ram.sv
hdl/lgs_row_unit.sv
hdl/life_grid_generation_step_unit.sv
verif/life_grid_generation_step_unit_test.sv
